// ===== src/partition_fit_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// partition_fit_allocator_macros
// assertion macros shared by the allocator rtl
// ----------------------------------------------------------------------------
`ifndef PARTITION_FIT_ALLOCATOR_MACROS_SVH
`define PARTITION_FIT_ALLOCATOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define PFA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define PFA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/pfa_pkg.sv =====
// ----------------------------------------------------------------------------
// pfa_pkg
// types and constants of the partition fit allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

	localparam int OP_W    = 2;
	localparam int SEL_W   = 4;
	localparam int AMT_W   = 16;
	localparam int HOLE_W  = 4;
	localparam int REM_W   = 16;
	localparam int MODE_W  = 2;
	localparam int ACT_W   = 5;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HOLES = 1'b1;

	localparam logic [MODE_W-1:0] FIT_MODE_RESET     = 2'd0;
	localparam logic [ACT_W-1:0]  ACTIVE_HOLES_RESET = 5'd16;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 2'd0,
		OP_RESTORE = 2'd1,
		OP_ALLOC   = 2'd2
	} op_t;

	typedef enum logic [MODE_W-1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2
	} fit_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESTORE,
		ST_UPDATE,
		ST_DONE
	} state_t;

endpackage

// ===== src/pfa_in_if.sv =====
// ----------------------------------------------------------------------------
// pfa_in_if
// request channel: operation, hole select and amount
// ----------------------------------------------------------------------------
interface pfa_in_if;
	import pfa_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   operation;
	logic [SEL_W-1:0]  hole_select;
	logic [AMT_W-1:0]  amount;

	modport source (output valid, output operation, output hole_select, output amount,
		input ready);
	modport sink (input valid, input operation, input hole_select, input amount,
		output ready);
endinterface

// ===== src/pfa_out_if.sv =====
// ----------------------------------------------------------------------------
// pfa_out_if
// result channel: grant flag, chosen hole and remainder
// ----------------------------------------------------------------------------
interface pfa_out_if;
	import pfa_pkg::*;

	logic              valid;
	logic              ready;
	logic              granted;
	logic [HOLE_W-1:0] chosen_hole;
	logic [REM_W-1:0]  remainder_after;

	modport source (output valid, output granted, output chosen_hole,
		output remainder_after, input ready);
	modport sink (input valid, input granted, input chosen_hole, input remainder_after,
		output ready);
endinterface

// ===== src/partition_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// partition_fit_allocator
// first, best or worst fit allocation over a table of free holes
// load and unused codes: after accept, ST_DONE loads the word into the output register
// allocate: scan of lim holes, then ST_UPDATE and ST_DONE; lim = min(active_holes, NUM_HOLES);
//   one hole compared per cycle through a single read port of the remainder memory
// restore: copy of lim holes, then ST_DONE; one original size copied per cycle
// one word at a time; ready again once the result sits in the output register;
//   a full output register holds the block
// async reset: config to defaults; control and per-hole valid bits cleared (sizes read 0)
// ----------------------------------------------------------------------------
module partition_fit_allocator #(
	parameter int NUM_HOLES = 16,
	parameter int SIZE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	pfa_in_if.sink                            req,
	pfa_out_if.source                         rsp,
	input  logic                              cfg_write,
	input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pfa_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import pfa_pkg::*;

	localparam int IDX_W = $clog2(NUM_HOLES);
	localparam int CNT_W = $clog2(NUM_HOLES + 1);

	state_t state_q, state_d;

	logic [MODE_W-1:0]    fit_mode_q;
	logic [ACT_W-1:0]     active_q;
	logic [CNT_W-1:0]     lim;
	logic [CNT_W-1:0]     cnt_q;
	logic                 scan_more;
	logic                 rd_issue;
	logic [IDX_W-1:0]     rd_addr;
	logic                 pend_s1;
	logic [IDX_W-1:0]     addr_s1;
	logic [SIZE_BITS-1:0] rem_rd_s1;
	logic [SIZE_BITS-1:0] orig_rd_s1;
	logic [SIZE_BITS-1:0] rd_val;
	logic [SIZE_BITS-1:0] orig_val;
	logic [NUM_HOLES-1:0] valid_q;

	logic [SIZE_BITS-1:0] amt_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_val_q;

	logic [SIZE_BITS-1:0] sub_a;
	logic [SIZE_BITS:0]   diff;
	logic                 fits;
	logic                 take;

	logic                 accept;
	op_t                  in_op;
	logic [SIZE_BITS-1:0] in_amt;
	logic                 load_ok;

	logic                 orig_we;
	logic [IDX_W-1:0]     orig_wa;
	logic [SIZE_BITS-1:0] orig_wd;
	logic                 rem_we;
	logic [IDX_W-1:0]     rem_wa;
	logic [SIZE_BITS-1:0] rem_wd;

	logic                 out_load;
	logic                 res_granted_q;
	logic [HOLE_W-1:0]    res_hole_q;
	logic [REM_W-1:0]     res_rem_q;
	logic                 out_valid_q;
	logic                 out_granted_q;
	logic [HOLE_W-1:0]    out_hole_q;
	logic [REM_W-1:0]     out_rem_q;

	logic [SIZE_BITS-1:0] orig_mem [NUM_HOLES];
	logic [SIZE_BITS-1:0] rem_mem  [NUM_HOLES];

	// request decode
	assign accept  = req.valid && req.ready;
	assign in_op   = op_t'(req.operation);
	assign in_amt  = SIZE_BITS'(req.amount);
	assign load_ok = 32'(req.hole_select) < NUM_HOLES;

	always_comb begin
		if (32'(active_q) > NUM_HOLES) begin
			lim = CNT_W'(NUM_HOLES);
		end else begin
			lim = CNT_W'(active_q);
		end
	end

	assign scan_more = cnt_q < lim;
	assign rd_addr   = cnt_q[IDX_W-1:0];
	assign rd_val    = valid_q[addr_s1] ? rem_rd_s1 : '0;
	assign orig_val  = valid_q[addr_s1] ? orig_rd_s1 : '0;

	// shared subtractor: fit test while scanning, new remainder on update
	assign sub_a = (state_q == ST_UPDATE) ? best_val_q : rd_val;
	assign diff  = {1'b0, sub_a} - {1'b0, amt_q};
	assign fits  = !diff[SIZE_BITS];

	assign take = (state_q == ST_SCAN) && pend_s1 && fits
		&& (!found_q
		|| ((fit_mode_q == FIT_BEST) && (rd_val < best_val_q))
		|| ((fit_mode_q == FIT_WORST) && (rd_val > best_val_q)));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_op)
						OP_ALLOC:   state_d = ST_SCAN;
						OP_RESTORE: state_d = ST_RESTORE;
						default:    state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				if (!scan_more && !pend_s1) state_d = ST_UPDATE;
			end
			ST_RESTORE: begin
				if (!scan_more && !pend_s1) state_d = ST_DONE;
			end
			ST_UPDATE: state_d = ST_DONE;
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		rd_issue  = ((state_q == ST_SCAN) || (state_q == ST_RESTORE)) && scan_more;
		out_load  = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);
		orig_we   = accept && (in_op == OP_LOAD) && load_ok;
		orig_wa   = IDX_W'(req.hole_select);
		orig_wd   = in_amt;
		rem_we    = 1'b0;
		rem_wa    = orig_wa;
		rem_wd    = orig_wd;
		case (state_q)
			ST_IDLE: rem_we = orig_we;
			ST_RESTORE: begin
				rem_we = pend_s1;
				rem_wa = addr_s1;
				rem_wd = orig_val;
			end
			ST_UPDATE: begin
				rem_we = found_q;
				rem_wa = best_idx_q;
				rem_wd = diff[SIZE_BITS-1:0];
			end
			default: rem_we = 1'b0;
		endcase
	end

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fit_mode_q  <= FIT_MODE_RESET;
			active_q    <= ACTIVE_HOLES_RESET;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				case (cfg_index)
					CFG_FIT_MODE:     fit_mode_q <= cfg_data[MODE_W-1:0];
					CFG_ACTIVE_HOLES: active_q   <= cfg_data[ACT_W-1:0];
					default:          ;
				endcase
			end
			if (accept) begin
				cnt_q <= '0;
			end else if (rd_issue) begin
				cnt_q <= cnt_q + 1'b1;
			end
			pend_s1 <= rd_issue;
			if (accept) begin
				found_q <= 1'b0;
			end else if (take) begin
				found_q <= 1'b1;
			end
			if (orig_we) valid_q[orig_wa] <= 1'b1;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (rd_issue) addr_s1 <= rd_addr;
		if (accept) begin
			amt_q         <= in_amt;
			res_granted_q <= 1'b0;
			res_hole_q    <= (orig_we) ? req.hole_select : '0;
			res_rem_q     <= (orig_we) ? REM_W'(in_amt) : '0;
		end
		if (take) begin
			best_idx_q <= addr_s1;
			best_val_q <= rd_val;
		end
		if (state_q == ST_UPDATE) begin
			res_granted_q <= found_q;
			res_hole_q    <= found_q ? HOLE_W'(best_idx_q) : '0;
			res_rem_q     <= found_q ? REM_W'(diff[SIZE_BITS-1:0]) : '0;
		end
		if (out_load) begin
			out_granted_q <= res_granted_q;
			out_hole_q    <= res_hole_q;
			out_rem_q     <= res_rem_q;
		end
	end

	// hole tables
	always_ff @(posedge clk) begin
		if (orig_we) orig_mem[orig_wa] <= orig_wd;
		orig_rd_s1 <= orig_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (rem_we) rem_mem[rem_wa] <= rem_wd;
		rem_rd_s1 <= rem_mem[rd_addr];
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.granted         = out_granted_q;
	assign rsp.chosen_hole     = out_hole_q;
	assign rsp.remainder_after = out_rem_q;

`include "partition_fit_allocator_macros.svh"

	`PFA_ASSERT_NXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
	`PFA_ASSERT_IMP(a_pend_in_walk, pend_s1, (state_q == ST_SCAN) || (state_q == ST_RESTORE), "stray read")
	`PFA_ASSERT_IMP(a_grant_fits, (state_q == ST_UPDATE) && found_q, !diff[SIZE_BITS], "bad grant")

endmodule
